@@ hw/rtl/pmfg_pkg.sv @@
// ----------------------------------------------------------------------------
// pmfg_pkg
// Shared constants and types of the prefix max free gap tracker.
// ----------------------------------------------------------------------------
package pmfg_pkg;

   // line geometry
   localparam int POSITIONS = 1024;
   localparam int POS_W     = 10;
   localparam int WORD_W    = 64;
   localparam int BIT_W     = 6;
   localparam int WORDS     = POSITIONS / WORD_W;
   localparam int WIDX_W    = $clog2(WORDS);

   // gap tree: heap layout, node 1 is the root, leaf i sits at POSITIONS + i
   localparam int NODE_W    = POS_W + 1;
   localparam int NODES     = 2 * POSITIONS;
   localparam int GAP_W     = 10;
   localparam int BLK_W     = 11;

   // command codes
   localparam logic CMD_PLACE = 1'b0;
   localparam logic CMD_ASK   = 1'b1;

   // scan directions
   localparam logic SCAN_DOWN = 1'b0;
   localparam logic SCAN_UP   = 1'b1;

   // tree operations
   localparam logic TREE_UPDATE = 1'b0;
   localparam logic TREE_QUERY  = 1'b1;

   typedef struct packed {
      logic             go;
      logic             dir;
      logic             set_en;
      logic [POS_W-1:0] pos;
   } scan_req_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic             occupied;
      logic [POS_W-1:0] hit;
   } scan_rsp_type;

   typedef struct packed {
      logic             go;
      logic             op;
      logic [POS_W-1:0] leaf;
      logic [GAP_W-1:0] val;
   } tree_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [GAP_W-1:0] max;
   } tree_rsp_type;

endpackage

@@ hw/rtl/prefix_max_free_gap_tracker.sv @@
// ----------------------------------------------------------------------------
// prefix_max_free_gap_tracker
// Places barriers on a line and answers whether a block fits before a slot.
//
//   channel   ports                                        handshake
//   request   req_command, req_position, req_block_size    start, busy
//   response  rsp_fits                                     rsp_strobe
//
// A place keeps busy high through a setup state, a downward and an upward
// word scan of the barrier map, then a tree update at the slot and, if the
// upward scan found a barrier, a second one at that barrier. A place on an
// occupied slot ends after the setup state. An ask keeps busy high through
// a setup state, one downward scan and a tree walk; an ask at slot zero
// skips the scan. After reset the node memory is cleared; busy stays high.
// rsp_strobe is high for one cycle per ask, in the cycle in which busy drops;
// the receiver cannot stall.
// ----------------------------------------------------------------------------
module prefix_max_free_gap_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic [pmfg_pkg::POS_W-1:0]  req_position,
   input  logic [pmfg_pkg::BLK_W-1:0]  req_block_size,
   output logic                        rsp_strobe,
   output logic                        rsp_fits
);
   import pmfg_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PRE   = 4'd1;
   localparam logic [3:0] S_PRE_W = 4'd2;
   localparam logic [3:0] S_NXT_W = 4'd3;
   localparam logic [3:0] S_U1    = 4'd4;
   localparam logic [3:0] S_U1_W  = 4'd5;
   localparam logic [3:0] S_U2    = 4'd6;
   localparam logic [3:0] S_U2_W  = 4'd7;
   localparam logic [3:0] S_Q     = 4'd8;
   localparam logic [3:0] S_Q_W   = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic             cmd_ff, cmd_in;
   logic [POS_W-1:0] x_ff, x_in, pre_ff, pre_in, nxt_ff, nxt_in;
   logic             nxt_ok_ff, nxt_ok_in;
   logic [BLK_W-1:0] blk_ff, blk_in;
   logic             strobe_ff, strobe_in, fits_ff, fits_in;

   scan_req_type     scan_req;
   scan_rsp_type     scan_rsp;
   tree_req_type     tree_req;
   tree_rsp_type     tree_rsp;
   logic [GAP_W-1:0] part, gap;

   pmfg_scan u_scan (.clock, .reset, .scan_req, .scan_rsp);
   pmfg_tree u_tree (.clock, .reset, .tree_req, .tree_rsp);

   assign busy       = (state_ff != S_IDLE) || tree_rsp.busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_fits   = fits_ff;
   assign part       = x_ff - pre_ff;
   assign gap        = (tree_rsp.max > part) ? tree_rsp.max : part;

   // sequence one word through scans and tree walks
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      x_in            = x_ff;
      pre_in          = pre_ff;
      nxt_in          = nxt_ff;
      nxt_ok_in       = nxt_ok_ff;
      blk_in          = blk_ff;
      strobe_in       = 1'b0;
      fits_in         = fits_ff;
      scan_req.go     = 1'b0;
      scan_req.dir    = SCAN_DOWN;
      scan_req.set_en = 1'b0;
      scan_req.pos    = x_ff;
      tree_req.go     = 1'b0;
      tree_req.op     = TREE_UPDATE;
      tree_req.leaf   = x_ff;
      tree_req.val    = part;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               cmd_in   = req_command;
               x_in     = req_position;
               blk_in   = req_block_size;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            if (cmd_ff == CMD_PLACE && scan_rsp.occupied) begin
               state_in = S_IDLE;
            end else if (x_ff == '0) begin
               pre_in   = '0;
               state_in = S_Q;
            end else begin
               scan_req.go = 1'b1;
               state_in    = S_PRE_W;
            end
         end
         S_PRE_W: begin
            if (scan_rsp.done) begin
               pre_in = scan_rsp.hit;
               if (cmd_ff == CMD_ASK) begin
                  state_in = S_Q;
               end else begin
                  scan_req.go  = 1'b1;
                  scan_req.dir = SCAN_UP;
                  state_in     = S_NXT_W;
               end
            end
         end
         S_NXT_W: begin
            if (scan_rsp.done) begin
               nxt_in    = scan_rsp.hit;
               nxt_ok_in = scan_rsp.found;
               state_in  = S_U1;
            end
         end
         S_U1: begin
            tree_req.go     = 1'b1;
            scan_req.set_en = 1'b1;
            state_in        = S_U1_W;
         end
         S_U1_W: begin
            if (tree_rsp.done) state_in = nxt_ok_ff ? S_U2 : S_IDLE;
         end
         S_U2: begin
            tree_req.go   = 1'b1;
            tree_req.leaf = nxt_ff;
            tree_req.val  = nxt_ff - x_ff;
            state_in      = S_U2_W;
         end
         S_U2_W: begin
            if (tree_rsp.done) state_in = S_IDLE;
         end
         S_Q: begin
            tree_req.go   = 1'b1;
            tree_req.op   = TREE_QUERY;
            tree_req.leaf = pre_ff;
            state_in      = S_Q_W;
         end
         S_Q_W: begin
            if (tree_rsp.done) begin
               strobe_in = 1'b1;
               fits_in   = {1'b0, gap} >= blk_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      cmd_ff    <= cmd_in;
      x_ff      <= x_in;
      pre_ff    <= pre_in;
      nxt_ff    <= nxt_in;
      nxt_ok_ff <= nxt_ok_in;
      blk_ff    <= blk_in;
      fits_ff   <= fits_in;
   end

   // a taken word keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy low after accept");

   // a response follows only the end of a tree query
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_Q_W) else $error("stray response");

   // a response lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("response repeated");

   // tree walks are never started while the node memory is cleared
   a_no_walk_in_clear: assert property (@(posedge clock) disable iff (reset)
      tree_rsp.busy |-> !tree_req.go) else $error("walk during clear");

endmodule

@@ hw/rtl/pmfg_scan.sv @@
// ----------------------------------------------------------------------------
// pmfg_scan
// Barrier map and nearest neighbor search, one 64-slot word per cycle.
// ----------------------------------------------------------------------------
module pmfg_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  pmfg_pkg::scan_req_type scan_req,
   output pmfg_pkg::scan_rsp_type scan_rsp
);
   import pmfg_pkg::*;

   logic [WORD_W-1:0] map_ff [WORDS];
   logic              active_ff, active_in;
   logic              dir_ff, dir_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic [WORD_W-1:0] mask_ff, mask_in;

   logic [WORD_W-1:0] word;
   logic [BIT_W-1:0]  hi_bit, lo_bit, hit_bit;
   logic              last_word;
   logic [WIDX_W-1:0] pos_word;
   logic [BIT_W-1:0]  pos_bit;
   logic [WORD_W-1:0] one_hot;

   assign pos_word = scan_req.pos[POS_W-1:BIT_W];
   assign pos_bit  = scan_req.pos[BIT_W-1:0];
   assign one_hot  = {{(WORD_W-1){1'b0}}, 1'b1} << pos_bit;

   // select the current word and encode its nearest set bit
   always_comb begin
      word   = map_ff[widx_ff] & mask_ff;
      hi_bit = '0;
      lo_bit = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (word[i]) hi_bit = BIT_W'(i);
      end
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word[i]) lo_bit = BIT_W'(i);
      end
      hit_bit   = dir_ff ? lo_bit : hi_bit;
      last_word = dir_ff ? (widx_ff == WIDX_W'(WORDS - 1)) : (widx_ff == '0);
   end

   // advance the search
   always_comb begin
      active_in = active_ff;
      dir_in    = dir_ff;
      widx_in   = widx_ff;
      mask_in   = mask_ff;
      if (scan_req.go) begin
         active_in = 1'b1;
         dir_in    = scan_req.dir;
         widx_in   = pos_word;
         mask_in   = (scan_req.dir == SCAN_UP) ? ~((one_hot << 1) - 1'b1)
                                               : (one_hot - 1'b1);
      end else if (active_ff) begin
         if (word != '0 || last_word) begin
            active_in = 1'b0;
         end else begin
            widx_in = dir_ff ? widx_ff + 1'b1 : widx_ff - 1'b1;
            mask_in = '1;
         end
      end
   end

   always_comb begin
      scan_rsp.done     = active_ff && (word != '0 || last_word);
      scan_rsp.found    = word != '0;
      scan_rsp.hit      = {widx_ff, hit_bit};
      scan_rsp.occupied = map_ff[pos_word][pos_bit];
   end

   // hold the map; slot zero is a permanent barrier
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         for (int w = 0; w < WORDS; w++) map_ff[w] <= '0;
         map_ff[0][0] <= 1'b1;
      end else begin
         active_ff <= active_in;
         if (scan_req.set_en) map_ff[pos_word][pos_bit] <= 1'b1;
      end
      dir_ff  <= dir_in;
      widx_ff <= widx_in;
      mask_ff <= mask_in;
   end

endmodule

@@ hw/rtl/pmfg_tree.sv @@
// ----------------------------------------------------------------------------
// pmfg_tree
// Max tree of gaps in a node memory, walked one level per cycle.
// ----------------------------------------------------------------------------
module pmfg_tree (
   input  logic                  clock,
   input  logic                  reset,
   input  pmfg_pkg::tree_req_type tree_req,
   output pmfg_pkg::tree_rsp_type tree_rsp
);
   import pmfg_pkg::*;

   localparam logic [1:0] T_CLEAR = 2'd0;
   localparam logic [1:0] T_IDLE  = 2'd1;
   localparam logic [1:0] T_UPD   = 2'd2;
   localparam logic [1:0] T_QRY   = 2'd3;

   logic [GAP_W-1:0]  mem [NODES];
   logic [GAP_W-1:0]  rd_ff;
   logic [1:0]        state_ff, state_in;
   logic [NODE_W-1:0] cnt_ff, cnt_in;
   logic [NODE_W-1:0] p_ff, p_in;
   logic [GAP_W-1:0]  cur_ff, cur_in;
   logic              use_ff, use_in;

   logic              we;
   logic [NODE_W-1:0] wa, ra, leaf_node, parent;
   logic [GAP_W-1:0]  wd, nv;
   logic              done;

   assign leaf_node = {1'b1, tree_req.leaf};
   assign parent    = p_ff >> 1;

   // sequence the walk
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      p_in     = p_ff;
      cur_in   = cur_ff;
      use_in   = use_ff;
      we       = 1'b0;
      wa       = cnt_ff;
      wd       = '0;
      ra       = p_ff;
      nv       = cur_ff;
      done     = 1'b0;
      unique case (state_ff)
         T_CLEAR: begin
            we     = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) state_in = T_IDLE;
         end
         T_IDLE: begin
            if (tree_req.go && tree_req.op == TREE_UPDATE) begin
               we       = 1'b1;
               wa       = leaf_node;
               wd       = tree_req.val;
               cur_in   = tree_req.val;
               p_in     = leaf_node;
               ra       = leaf_node ^ NODE_W'(1);
               state_in = T_UPD;
            end else if (tree_req.go) begin
               ra       = leaf_node;
               use_in   = 1'b1;
               cur_in   = '0;
               p_in     = leaf_node;
               state_in = T_QRY;
            end
         end
         T_UPD: begin
            nv     = (rd_ff > cur_ff) ? rd_ff : cur_ff;
            we     = 1'b1;
            wa     = parent;
            wd     = nv;
            cur_in = nv;
            p_in   = parent;
            ra     = parent ^ NODE_W'(1);
            if (parent == NODE_W'(1)) begin
               done     = 1'b1;
               state_in = T_IDLE;
            end
         end
         T_QRY: begin
            nv     = (use_ff && rd_ff > cur_ff) ? rd_ff : cur_ff;
            cur_in = nv;
            ra     = p_ff - 1'b1;
            use_in = p_ff[0];
            p_in   = parent;
            if (p_ff == NODE_W'(1)) begin
               done     = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      tree_rsp.busy = state_ff == T_CLEAR;
      tree_rsp.done = done;
      tree_rsp.max  = nv;
   end

   // node memory with registered read
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      p_ff   <= p_in;
      cur_ff <= cur_in;
      use_ff <= use_in;
   end

endmodule
